/* hdl/sitpd_pkg.sv */
// ----------------------------------------------------------------------------
// sitpd_pkg
// Shared types and constants for the signed integer to padded decimal block.
// ----------------------------------------------------------------------------
package sitpd_pkg;

  localparam int unsigned CNT_W = 6;

  localparam logic [CNT_W-1:0] MAX_FIELD = 6'd63;

  localparam logic [5:0] CH_SPACE = 6'd32;
  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [5:0] CH_ZERO  = 6'd48;

  localparam logic [3:0] DAB_LIMIT = 4'd5;
  localparam logic [3:0] DAB_ADJ   = 4'd3;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic             neg;
    logic [CNT_W-1:0] width;
  } sitpd_desc_t;

endpackage

/* hdl/sitpd_front.sv */
// ----------------------------------------------------------------------------
// sitpd_front
// Accepts input words, forms sign, magnitude and saturated field width, and
// holds them in a two-entry queue for the converter.
// ----------------------------------------------------------------------------
module sitpd_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [VALUE_BITS-1:0]   value,
  input  logic [sitpd_pkg::CNT_W-1:0]    min_width,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           q_valid,
  input  logic                           q_ready,
  output sitpd_pkg::sitpd_desc_t         q_desc,
  output logic [VALUE_BITS-1:0]          q_mag
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0]  raw;
  logic [VALUE_BITS-1:0]  mag_c;
  sitpd_pkg::sitpd_desc_t desc_c;
  logic                   push;
  logic                   pop;

  sitpd_pkg::sitpd_desc_t qd [DEPTH];
  logic [VALUE_BITS-1:0]  qm [DEPTH];
  logic [PTR_W-1:0]       wptr;
  logic [PTR_W-1:0]       rptr;
  logic [CNT_QW-1:0]      count;

  assign raw          = value;
  assign desc_c.neg   = raw[VALUE_BITS-1];
  assign mag_c        = desc_c.neg ? (~raw + VALUE_BITS'(1)) : raw;
  assign desc_c.width = (min_width > sitpd_pkg::MAX_FIELD) ? sitpd_pkg::MAX_FIELD : min_width;

  assign in_ready = (count != CNT_QW'(DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;
  assign q_desc   = qd[rptr];
  assign q_mag    = qm[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qd[wptr] <= desc_c;
      qm[wptr] <= mag_c;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_QW'(1);
      end else if (pop && !push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

endmodule

/* hdl/sitpd_back.sv */
// ----------------------------------------------------------------------------
// sitpd_back
// Converts a queued magnitude to BCD four bits per cycle (shift and add 3),
// sizes the text, then emits one ASCII character per cycle into an output
// register while that register is empty or being taken.
// ----------------------------------------------------------------------------
module sitpd_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  sitpd_pkg::sitpd_desc_t       q_desc,
  input  logic [VALUE_BITS-1:0]        q_mag,
  output logic [5:0]                   character,
  output logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready
);

  localparam int MAG_W  = ((VALUE_BITS + 3) / 4) * 4;
  localparam int STEPS  = MAG_W / 4;
  localparam int STEP_W = $clog2(STEPS);
  localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DIG_IW = $clog2(NDIG);
  localparam int CW     = sitpd_pkg::CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SIZE, S_EMIT} state_t;

  state_t                 state;
  logic [MAG_W-1:0]       sh;
  logic [NDIG-1:0][3:0]   bcd;
  logic [STEP_W-1:0]      step;
  logic                   neg;
  logic [CW-1:0]          width;
  logic [CW-1:0]          total;
  logic [CW-1:0]          pad;
  logic [CW-1:0]          pos;

  logic [MAG_W-1:0]       sh_next;
  logic [NDIG-1:0][3:0]   bcd_next;
  logic [CW-1:0]          nd_c;
  logic [CW-1:0]          textlen_c;
  logic [CW-1:0]          total_c;
  logic [CW-1:0]          didx;
  logic [3:0]             digit;
  logic [5:0]             char_c;
  logic                   last_c;
  logic                   emit;
  logic                   bcd_ok;

  assign q_ready = (state == S_IDLE);

  always_comb begin
    logic [NDIG-1:0][3:0] d;
    logic [MAG_W-1:0]     s;
    d = bcd;
    s = sh;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < NDIG; i++) begin
        if (d[i] >= sitpd_pkg::DAB_LIMIT) begin
          d[i] = d[i] + sitpd_pkg::DAB_ADJ;
        end
      end
      {d, s} = {d, s} << 1;
    end
    bcd_next = d;
    sh_next  = s;
  end

  always_comb begin
    nd_c   = CW'(1);
    bcd_ok = 1'b1;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i] != 4'd0) begin
        nd_c = CW'(i + 1);
      end
      if (bcd[i] > sitpd_pkg::DIGIT_MAX) begin
        bcd_ok = 1'b0;
      end
    end
    textlen_c = nd_c + CW'(neg);
    total_c   = (textlen_c > width) ? textlen_c : width;
  end

  assign didx   = total - CW'(1) - pos;
  assign digit  = bcd[didx[DIG_IW-1:0]];
  assign last_c = (pos == total - CW'(1));
  assign emit   = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    if (pos < pad) begin
      char_c = sitpd_pkg::CH_SPACE;
    end else if (neg && pos == pad) begin
      char_c = sitpd_pkg::CH_MINUS;
    end else begin
      char_c = sitpd_pkg::CH_ZERO + {2'b00, digit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            sh    <= MAG_W'(q_mag);
            bcd   <= '0;
            step  <= '0;
            neg   <= q_desc.neg;
            width <= q_desc.width;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          sh   <= sh_next;
          bcd  <= bcd_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(STEPS - 1)) begin
            state <= S_SIZE;
          end
        end
        S_SIZE: begin
          total <= total_c;
          pad   <= total_c - textlen_c;
          pos   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            character <= char_c;
            last      <= last_c;
            pos       <= pos + CW'(1);
            if (last_c) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pos_in_text: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> pos < total)
    else $error("emit position beyond text");

  a_total_covers_width: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> total >= width)
    else $error("text shorter than field width");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    state == S_SIZE |-> bcd_ok)
    else $error("conversion left a non-decimal digit");

  a_pending_is_last: assert property (@(posedge clk) disable iff (rst)
    (state != S_EMIT && out_valid) |-> last)
    else $error("back end left text unfinished");

endmodule

/* hdl/signed_int_to_padded_decimal_top.sv */
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_top
// Signed integer to right-justified decimal ASCII text, one character per
// output word, spaces then optional minus then digits, last on the final one.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   value, min_width
//   out      out_valid / out_ready character, last
//
// In the converter a word passes through the states idle, conversion, sizing
// and emission; the shift and add-3 unit handles four magnitude bits per
// cycle, then one character leaves per cycle while the output is not
// stalled. A two-entry queue takes new words while the converter works.
// Synchronous reset clears the queue, the converter state and out_valid.
// A stalled output holds the current character and pauses emission.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [5:0]                   min_width,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic [5:0]                   character,
  output logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready
);

  logic                   q_valid;
  logic                   q_ready;
  sitpd_pkg::sitpd_desc_t q_desc;
  logic [VALUE_BITS-1:0]  q_mag;

  sitpd_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .min_width (min_width),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_desc    (q_desc),
    .q_mag     (q_mag)
  );

  sitpd_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_desc    (q_desc),
    .q_mag     (q_mag),
    .character (character),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
